FILE: src/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_PLAY   = 3'd1;
  localparam logic [2:0] REQ_PAUSE  = 3'd2;
  localparam logic [2:0] REQ_RESUME = 3'd3;
  localparam logic [2:0] REQ_STOP   = 3'd4;
  localparam logic [2:0] REQ_SET    = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END    = 4'd3;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] elapsed_ms;
    logic        loop_enable;
    logic [15:0] repeat_target;
    logic [7:0]  frame_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  shown_frame;
    logic [1:0]  play_state;
    logic [15:0] completed_plays;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/sfs_ctrl.sv
`default_nettype none

module sfs_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  input  sfs_pkg::dp_stat_t stat_i,
  output sfs_pkg::dp_cmd_t  cmd_o
);

  sfs_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      sfs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = sfs_pkg::ST_RUN;
        end
      end
      sfs_pkg::ST_RUN: begin
        // One frame advance per cycle until the accumulator drops below a frame time or playback stops.
        if (stat_i.more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = sfs_pkg::ST_DONE;
        end
      end
      sfs_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load = 1'b1;
          state_d    = sfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/sfs_dp.sv
`default_nettype none

module sfs_dp #(
  parameter int MAX_FRAMES = 256
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [sfs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [sfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  sfs_pkg::in_item_t                  in_item_i,
  input  sfs_pkg::dp_cmd_t                   cmd_i,
  output sfs_pkg::dp_stat_t                  stat_o,
  output sfs_pkg::out_item_t                 out_item_o
);

  logic [8:0]  frames_count_q;
  logic [15:0] frame_time_q;
  logic [7:0]  range_start_q;
  logic [7:0]  range_end_q;

  logic [7:0]     frame_q, frame_d;
  sfs_pkg::mode_e mode_q, mode_d;
  logic [16:0]    accum_q, accum_d;
  logic [15:0]    pass_q, pass_d;
  logic           loop_q, loop_d;
  logic [15:0]    target_q, target_d;
  logic           tick_q, tick_d;
  sfs_pkg::out_item_t out_q;

  logic [16:0] ft;
  logic [8:0]  next_frame;
  logic        wrap;
  logic [15:0] pass_inc;
  logic        halt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_count_q <= 9'd256;
      frame_time_q   <= 16'd100;
      range_start_q  <= 8'd0;
      range_end_q    <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfs_pkg::CFG_FRAMES_COUNT: frames_count_q <= cfg_data_i[8:0];
        sfs_pkg::CFG_FRAME_TIME:   frame_time_q   <= cfg_data_i;
        sfs_pkg::CFG_RANGE_START:  range_start_q  <= cfg_data_i[7:0];
        sfs_pkg::CFG_RANGE_END:    range_end_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // A frame time of zero counts as one millisecond.
  assign ft         = (frame_time_q == '0) ? 17'd1 : {1'b0, frame_time_q};
  assign next_frame = {1'b0, frame_q} + 9'd1;
  assign wrap       = next_frame > {1'b0, range_end_q};
  assign pass_inc   = (pass_q == 16'hFFFF) ? pass_q : pass_q + 16'd1;
  assign halt       = !loop_q && (target_q != '0) && (pass_inc >= target_q);

  assign stat_o.more = tick_q && (mode_q == sfs_pkg::MODE_PLAYING) && (accum_q >= ft);

  always_comb begin
    frame_d  = frame_q;
    mode_d   = mode_q;
    accum_d  = accum_q;
    pass_d   = pass_q;
    loop_d   = loop_q;
    target_d = target_q;
    tick_d   = tick_q;
    if (cmd_i.exec) begin
      tick_d = (in_item_i.req_type == sfs_pkg::REQ_TICK);
      unique case (in_item_i.req_type)
        sfs_pkg::REQ_TICK: begin
          if (mode_q == sfs_pkg::MODE_PLAYING) begin
            accum_d = accum_q + {1'b0, in_item_i.elapsed_ms};
          end
        end
        sfs_pkg::REQ_PLAY: begin
          loop_d   = in_item_i.loop_enable;
          target_d = in_item_i.repeat_target;
          pass_d   = '0;
          mode_d   = sfs_pkg::MODE_PLAYING;
          accum_d  = '0;
        end
        sfs_pkg::REQ_PAUSE: begin
          if (mode_q == sfs_pkg::MODE_PLAYING) begin
            mode_d = sfs_pkg::MODE_PAUSED;
          end
        end
        sfs_pkg::REQ_RESUME: begin
          if (mode_q == sfs_pkg::MODE_PAUSED) begin
            mode_d = sfs_pkg::MODE_PLAYING;
          end
        end
        sfs_pkg::REQ_STOP: begin
          mode_d  = sfs_pkg::MODE_STOPPED;
          frame_d = range_start_q;
          accum_d = '0;
          pass_d  = '0;
        end
        sfs_pkg::REQ_SET: begin
          if (({1'b0, in_item_i.frame_index} < frames_count_q) &&
              (32'(in_item_i.frame_index) < MAX_FRAMES)) begin
            frame_d = in_item_i.frame_index;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      accum_d = accum_q - ft;
      if (wrap) begin
        pass_d = pass_inc;
        if (halt) begin
          // The repeat target is reached: hold the last frame and drop leftover time.
          mode_d  = sfs_pkg::MODE_STOPPED;
          frame_d = range_end_q;
          accum_d = '0;
        end else begin
          frame_d = range_start_q;
        end
      end else begin
        frame_d = next_frame[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      mode_q   <= sfs_pkg::MODE_STOPPED;
      accum_q  <= '0;
      pass_q   <= '0;
      loop_q   <= 1'b1;
      target_q <= '0;
      tick_q   <= 1'b0;
    end else begin
      frame_q  <= frame_d;
      mode_q   <= mode_d;
      accum_q  <= accum_d;
      pass_q   <= pass_d;
      loop_q   <= loop_d;
      target_q <= target_d;
      tick_q   <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.shown_frame     <= frame_q;
      out_q.play_state      <= mode_q;
      out_q.completed_plays <= pass_q;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

FILE: src/sprite_frame_sequencer.sv
`default_nettype none

// Sprite animation frame sequencer. Each accepted item is one event (tick, play, pause,
// resume, stop or set frame) and yields exactly one result carrying the shown frame, the
// play state and the saturating completed-play count. Items are handled one at a time.
// A non-tick event passes through the idle, run and done states; its result is loaded
// in the done state once the output register is free. A tick stays in the run state
// while a frame time is left and playback goes on, as the shared subtract-and-advance
// step retires one frame time per cycle from the 17-bit accumulator. The
// result sits in an output register, so a new item is taken while a finished result
// still waits on a stalled output; a second finished result waits until that register
// is free. Configuration registers are always ready and must be written only while idle.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = 256
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [sfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [sfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  sfs_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output sfs_pkg::out_item_t             out_item_o
);

  sfs_pkg::dp_cmd_t  cmd;
  sfs_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sfs_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: src/sfs_checker.sv
`default_nettype none

module sfs_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_i,
  input wire                out_valid_i,
  input wire                out_stall_i,
  input sfs_pkg::out_item_t out_item_i
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_item_i))
    else $error("stalled result changed");

  // The block works on one item at a time, so it stalls right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("second item taken while busy");

  // The play state code three is never reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_item_i.play_state != 2'd3)
    else $error("invalid play state reported");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire

FILE: bench/sfs_status_checker.sv
`timescale 1ns / 1ps

module sfs_status_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  input  wire                            cfg_ready_i,
  input  wire [sfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [sfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                            in_valid_i,
  input  wire                            in_stall_i,
  input  sfs_pkg::in_item_t              in_item_i,
  input  wire                            out_valid_i,
  input  wire                            out_stall_i,
  input  sfs_pkg::out_item_t             out_item_i,
  output int                             mismatches_o,
  output int                             pending_o
);
  import sfs_pkg::*;

  // Shadow of the configuration registers.
  logic [8:0]  cfg_frames;
  logic [15:0] cfg_ftime;
  logic [7:0]  cfg_first;
  logic [7:0]  cfg_last;

  // Shadow of the sequencer state.
  logic [7:0]  cur_frame;
  mode_e       cur_mode;
  logic [16:0] acc_ms;
  logic [15:0] plays;
  logic        looping;
  logic [15:0] play_goal;

  out_item_t   due_status[$];
  int          fail_cnt = 0;
  int          due_cnt = 0;

  assign mismatches_o = fail_cnt;
  assign pending_o    = due_cnt;

  task automatic flag(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  // One frame advance inside the playback range.
  task automatic advance_frame();
    logic [8:0] nxt;
    nxt = {1'b0, cur_frame} + 9'd1;
    if (nxt > {1'b0, cfg_last}) begin
      if (plays != 16'hFFFF) begin
        plays = plays + 16'd1;
      end
      if (!looping && play_goal != 16'd0 && plays >= play_goal) begin
        cur_mode  = MODE_STOPPED;
        cur_frame = cfg_last;
      end else begin
        cur_frame = cfg_first;
      end
    end else begin
      cur_frame = nxt[7:0];
    end
  endtask

  task automatic apply_event(input in_item_t ev, output out_item_t status);
    logic [16:0] ft;
    ft = (cfg_ftime == 16'd0) ? 17'd1 : {1'b0, cfg_ftime};
    case (ev.req_type)
      REQ_TICK: begin
        if (cur_mode == MODE_PLAYING) begin
          acc_ms = acc_ms + {1'b0, ev.elapsed_ms};
          while (acc_ms >= ft && cur_mode == MODE_PLAYING) begin
            acc_ms = acc_ms - ft;
            advance_frame();
          end
          // Time left over when playback ends on the last pass is dropped.
          if (cur_mode != MODE_PLAYING) begin
            acc_ms = '0;
          end
        end
      end
      REQ_PLAY: begin
        looping   = ev.loop_enable;
        play_goal = ev.repeat_target;
        plays     = '0;
        cur_mode  = MODE_PLAYING;
        acc_ms    = '0;
      end
      REQ_PAUSE: begin
        if (cur_mode == MODE_PLAYING) begin
          cur_mode = MODE_PAUSED;
        end
      end
      REQ_RESUME: begin
        if (cur_mode == MODE_PAUSED) begin
          cur_mode = MODE_PLAYING;
        end
      end
      REQ_STOP: begin
        cur_mode  = MODE_STOPPED;
        cur_frame = cfg_first;
        acc_ms    = '0;
        plays     = '0;
      end
      REQ_SET: begin
        if ({1'b0, ev.frame_index} < cfg_frames) begin
          cur_frame = ev.frame_index;
        end
      end
      default: ;
    endcase
    status.shown_frame     = cur_frame;
    status.play_state      = cur_mode;
    status.completed_plays = plays;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t status;
    if (!rst_ni) begin
      cfg_frames = 9'd256;
      cfg_ftime  = 16'd100;
      cfg_first  = 8'd0;
      cfg_last   = 8'd255;
      cur_frame  = 8'd0;
      cur_mode   = MODE_STOPPED;
      acc_ms     = '0;
      plays      = '0;
      looping    = 1'b1;
      play_goal  = '0;
      due_status.delete();
      due_cnt    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRAMES_COUNT: cfg_frames = cfg_data_i[8:0];
          CFG_FRAME_TIME:   cfg_ftime  = cfg_data_i;
          CFG_RANGE_START:  cfg_first  = cfg_data_i[7:0];
          CFG_RANGE_END:    cfg_last   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_status.size() == 0) begin
          flag($sformatf("result frame %0d state %0d plays %0d with nothing due",
                         out_item_i.shown_frame, out_item_i.play_state,
                         out_item_i.completed_plays));
        end else begin
          want = due_status.pop_front();
          if (out_item_i.shown_frame !== want.shown_frame) begin
            flag($sformatf("shown_frame got %0d expected %0d",
                           out_item_i.shown_frame, want.shown_frame));
          end
          if (out_item_i.play_state !== want.play_state) begin
            flag($sformatf("play_state got %0d expected %0d",
                           out_item_i.play_state, want.play_state));
          end
          if (out_item_i.completed_plays !== want.completed_plays) begin
            flag($sformatf("completed_plays got %0d expected %0d",
                           out_item_i.completed_plays, want.completed_plays));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_event(in_item_i, status);
        due_status.insert(due_status.size(), status);
      end
      due_cnt = due_status.size();
    end
  end

endmodule

FILE: bench/tb_sprite_frame_sequencer.sv
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  // Request codes and a register index that the block must ignore.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

  // A tick retires its frame times one per cycle, while the accumulator holds a frame time.
  localparam int IDLE_LIMIT  = 300000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 88;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  int                    mismatches;
  int                    pending;
  int                    idle_cycles = 0;
  logic                  steady;
  int                    ftime_now;

  sprite_frame_sequencer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  sfs_status_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sprite_frame_sequencer verification failed");
      $finish;
    end
  end

  // Result side backpressure: mostly short stalls, a few long ones, and
  // occasional long stretches with no stall at all.
  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(30, 150);
      repeat (run) @(negedge clk);
      out_stall = 1'b1;
      run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      repeat (run) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(5, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_event(input in_item_t ev);
    int gap;
    in_item  = ev;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic post(input logic [2:0] req, input logic [15:0] ms, input logic lp,
                      input logic [15:0] goal, input logic [7:0] idx);
    in_item_t ev;
    ev.req_type      = req;
    ev.elapsed_ms    = ms;
    ev.loop_enable   = lp;
    ev.repeat_target = goal;
    ev.frame_index   = idx;
    send_event(ev);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [8:0] frames, input logic [15:0] ft,
                          input logic [7:0] first, input logic [7:0] last);
    wait_drained();
    write_reg(CFG_FRAMES_COUNT, {7'd0, frames});
    write_reg(CFG_FRAME_TIME, ft);
    write_reg(CFG_RANGE_START, {8'd0, first});
    write_reg(CFG_RANGE_END, {8'd0, last});
    ftime_now = (ft == 16'd0) ? 1 : int'(ft);
  endtask

  task automatic random_setup(input int ph);
    logic [8:0]  frames;
    logic [15:0] ft;
    int          top_frame;
    int          first;
    int          last;
    case ($urandom_range(0, 4))
      0: frames = 9'd1;
      1: frames = 9'd256;
      2: frames = 9'd511;
      default: frames = 9'($urandom_range(2, 256));
    endcase
    // Rotate through tiny, moderate and long frame times.
    case (ph % 3)
      0: ft = 16'($urandom_range(0, 4));
      1: ft = 16'($urandom_range(5, 300));
      default: ft = 16'($urandom_range(1000, 65535));
    endcase
    top_frame = (frames > 9'd256) ? 255 : int'(frames) - 1;
    if ($urandom_range(0, 4) == 0) begin
      first = $urandom_range(0, 255);
      last  = $urandom_range(0, 255);
    end else begin
      first = $urandom_range(0, top_frame);
      last  = $urandom_range(first, top_frame);
    end
    set_regs(frames, ft, 8'(first), 8'(last));
  endtask

  task automatic random_event();
    in_item_t    ev;
    logic [63:0] raw;
    int          r;
    int          cap;
    raw = {$urandom, $urandom};
    ev  = raw[$bits(in_item_t)-1:0];
    r   = $urandom_range(0, 99);
    if (r < 55) begin
      ev.req_type = REQ_TICK;
      // Keep the number of frames per tick modest so the run stays short.
      if (ftime_now >= 256) begin
        ev.elapsed_ms = 16'($urandom);
      end else begin
        cap = ($urandom_range(0, 9) == 0) ? 40 * ftime_now : 3 * ftime_now;
        if (cap > 65535) begin
          cap = 65535;
        end
        ev.elapsed_ms = 16'($urandom_range(0, cap));
      end
    end else if (r < 67) begin
      ev.req_type    = REQ_PLAY;
      ev.loop_enable = ($urandom_range(0, 9) < 3);
      case ($urandom_range(0, 9))
        0, 1: ev.repeat_target = 16'd0;
        2, 3, 4: ev.repeat_target = 16'($urandom);
        default: ev.repeat_target = 16'($urandom_range(1, 3));
      endcase
    end else if (r < 74) begin
      ev.req_type = REQ_PAUSE;
    end else if (r < 81) begin
      ev.req_type = REQ_RESUME;
    end else if (r < 86) begin
      ev.req_type = REQ_STOP;
    end else if (r < 95) begin
      ev.req_type = REQ_SET;
    end else begin
      ev.req_type = ($urandom_range(0, 1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
    end
    send_event(ev);
  endtask

  initial begin
    int ph;
    int n;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    steady    = 1'b0;
    ftime_now = 100;
    rst_n     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: 256 frames, 100 ms per frame, full range.
    post(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 8'd0);
    post(REQ_SET, 16'd0, 1'b0, 16'd0, 8'd255);
    post(REQ_PLAY, 16'd0, 1'b0, 16'd1, 8'd0);
    // The single pass ends at the range end and playback stops there.
    post(REQ_TICK, 16'd100, 1'b0, 16'd0, 8'd0);
    post(REQ_PAUSE, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_RESUME, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_PLAY, 16'd0, 1'b1, 16'hFFFF, 8'd0);
    post(REQ_TICK, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_TICK, 16'd250, 1'b0, 16'd0, 8'd0);
    post(REQ_PAUSE, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 8'd0);
    post(REQ_RESUME, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_SPARE_A, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF);
    post(REQ_SPARE_B, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF);
    post(REQ_STOP, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_PLAY, 16'd0, 1'b0, 16'd0, 8'd0);
    post(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 8'd0);

    // One-frame strip with the longest frame time; the accumulator needs all 17 bits.
    set_regs(9'd1, 16'hFFFF, 8'd0, 8'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    post(REQ_SET, 16'd0, 1'b0, 16'd0, 8'd1);
    post(REQ_PLAY, 16'd0, 1'b0, 16'd3, 8'd0);
    post(REQ_TICK, 16'hFFFE, 1'b0, 16'd0, 8'd0);
    repeat (3) post(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 8'd0);

    // Range end below range start: every advance wraps and counts a pass.
    set_regs(9'd511, 16'd1, 8'd200, 8'd100);
    post(REQ_SET, 16'd0, 1'b0, 16'd0, 8'd250);
    post(REQ_PLAY, 16'd0, 1'b1, 16'd0, 8'd0);
    post(REQ_TICK, 16'd3, 1'b0, 16'd0, 8'd0);
    // A frame past the range end wraps on its next advance.
    set_regs(9'd511, 16'd1, 8'd10, 8'd20);
    post(REQ_SET, 16'd0, 1'b0, 16'd0, 8'd250);
    post(REQ_TICK, 16'd1, 1'b0, 16'd0, 8'd0);

    // Zero frame time on a one-frame range: saturate the pass count,
    // then reach the largest repeat target.
    set_regs(9'd256, 16'd0, 8'd0, 8'd0);
    post(REQ_PLAY, 16'd0, 1'b1, 16'd0, 8'd0);
    post(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 8'd0);
    post(REQ_TICK, 16'd2, 1'b0, 16'd0, 8'd0);
    post(REQ_PLAY, 16'd0, 1'b0, 16'hFFFF, 8'd0);
    post(REQ_TICK, 16'hFFFF, 1'b0, 16'd0, 8'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      random_setup(ph);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        steady = (n >= 20 && n < 45);
        if ($urandom_range(0, 49) == 0) begin
          wait_drained();
        end
        random_event();
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sprite_frame_sequencer verification clean");
    end else begin
      $display("sprite_frame_sequencer verification failed");
    end
    $finish;
  end

endmodule
